FILE: src/ytps_pkg.sv
// shared types, constants and helpers for the young tableau priority store
// no dependencies
package ytps_pkg;

   localparam int MAX_ROWS = 8;
   localparam int MAX_COLS = 8;
   localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int RDIM_W = $clog2(MAX_ROWS + 1);
   localparam int CDIM_W = $clog2(MAX_COLS + 1);
   localparam int VAL_W = 32;
   localparam int CSR_W = 4;

   typedef enum logic [1:0] {
      DIR_UP,
      DIR_LEFT,
      DIR_RIGHT,
      DIR_DOWN
   } dir_type;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_LOAD,
      OP_CLEAR,
      OP_SWAP
   } cell_op_type;

   typedef enum logic [1:0] {
      ST_DONE        = 2'd0,
      ST_INSERT_FULL = 2'd1,
      ST_EXTRACT_EMPTY = 2'd2
   } status_type;

   typedef enum logic {
      KIND_INSERT  = 1'b0,
      KIND_EXTRACT = 1'b1
   } kind_type;

   typedef enum logic {
      CSR_ROWS = 1'b0,
      CSR_COLS = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INS_WALK,
      S_EXT_WALK,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic             occ;
      logic [VAL_W-1:0] val;
   } cell_data_type;

   localparam cell_data_type CELL_EMPTY = '{occ: 1'b0, val: '0};

   typedef struct packed {
      cell_op_type       op;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      dir_type           dir;
      logic [RDIM_W-1:0] rows;
      logic [CDIM_W-1:0] cols;
      logic [VAL_W-1:0]  load_val;
   } cell_cmd_type;

   typedef struct packed {
      logic          sel;
      cell_data_type data;
      logic          ins_go;
      dir_type       ins_dir;
      logic          ext_go;
      dir_type       ext_dir;
   } cell_view_type;

   // strictly smaller key, empty counts as plus infinity
   function automatic logic cell_less(input cell_data_type a, input cell_data_type b);
      logic r;
      if (!a.occ) begin
         r = 1'b0;
      end else if (!b.occ) begin
         r = 1'b1;
      end else begin
         r = $signed(a.val) < $signed(b.val);
      end
      return r;
   endfunction

endpackage

FILE: src/ytps_cell.sv
// one tableau cell: holds a value and decides the local step of a walk
// depends on ytps_pkg
module ytps_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [ytps_pkg::ROW_W-1:0] my_row,
   input  logic [ytps_pkg::COL_W-1:0] my_col,
   input  ytps_pkg::cell_cmd_type    cmd,
   input  ytps_pkg::cell_data_type   up_in,
   input  ytps_pkg::cell_data_type   left_in,
   input  ytps_pkg::cell_data_type   right_in,
   input  ytps_pkg::cell_data_type   down_in,
   output ytps_pkg::cell_view_type   view
);

   ytps_pkg::cell_data_type data_ff, data_in;
   logic is_here, is_next;
   logic has_up, has_left, has_right, has_down;
   ytps_pkg::cell_data_type from_dir, from_opp;
   logic [ytps_pkg::ROW_W:0] row_x, cmd_row_x;
   logic [ytps_pkg::COL_W:0] col_x, cmd_col_x;

   always_comb begin
      row_x = {1'b0, my_row};
      col_x = {1'b0, my_col};
      cmd_row_x = {1'b0, cmd.row};
      cmd_col_x = {1'b0, cmd.col};
      is_here = (my_row == cmd.row) && (my_col == cmd.col);
      case (cmd.dir)
         ytps_pkg::DIR_UP: begin
            is_next = (row_x + 1'b1 == cmd_row_x) && (my_col == cmd.col);
            from_dir = up_in;
            from_opp = down_in;
         end
         ytps_pkg::DIR_LEFT: begin
            is_next = (col_x + 1'b1 == cmd_col_x) && (my_row == cmd.row);
            from_dir = left_in;
            from_opp = right_in;
         end
         ytps_pkg::DIR_RIGHT: begin
            is_next = (col_x == cmd_col_x + 1'b1) && (my_row == cmd.row);
            from_dir = right_in;
            from_opp = left_in;
         end
         default: begin
            is_next = (row_x == cmd_row_x + 1'b1) && (my_col == cmd.col);
            from_dir = down_in;
            from_opp = up_in;
         end
      endcase

      data_in = data_ff;
      case (cmd.op)
         ytps_pkg::OP_LOAD: begin
            if (is_here) begin
               data_in.occ = 1'b1;
               data_in.val = cmd.load_val;
            end
         end
         ytps_pkg::OP_CLEAR: begin
            if (is_here) begin
               data_in = ytps_pkg::CELL_EMPTY;
            end
         end
         ytps_pkg::OP_SWAP: begin
            if (is_here) begin
               data_in = from_dir;
            end else if (is_next) begin
               data_in = from_opp;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff <= ytps_pkg::CELL_EMPTY;
      end else begin
         data_ff <= data_in;
      end
   end

   // local step decisions, used only when this cell is the walk position
   always_comb begin
      has_up = (my_row != '0);
      has_left = (my_col != '0);
      has_right = (ytps_pkg::CDIM_W'(my_col) + 1'b1) < cmd.cols;
      has_down = (ytps_pkg::RDIM_W'(my_row) + 1'b1) < cmd.rows;

      view.sel = is_here;
      view.data = data_ff;

      view.ins_go = 1'b0;
      view.ins_dir = ytps_pkg::DIR_UP;
      if (has_up && has_left) begin
         view.ins_dir = ytps_pkg::cell_less(up_in, left_in) ? ytps_pkg::DIR_LEFT
                                                            : ytps_pkg::DIR_UP;
         view.ins_go = ytps_pkg::cell_less(data_ff,
            (view.ins_dir == ytps_pkg::DIR_UP) ? up_in : left_in);
      end else if (has_up) begin
         view.ins_go = ytps_pkg::cell_less(data_ff, up_in);
      end else if (has_left) begin
         view.ins_dir = ytps_pkg::DIR_LEFT;
         view.ins_go = ytps_pkg::cell_less(data_ff, left_in);
      end

      view.ext_go = 1'b0;
      view.ext_dir = ytps_pkg::DIR_RIGHT;
      if (has_right && has_down) begin
         view.ext_dir = ytps_pkg::cell_less(down_in, right_in) ? ytps_pkg::DIR_DOWN
                                                               : ytps_pkg::DIR_RIGHT;
         view.ext_go = (view.ext_dir == ytps_pkg::DIR_DOWN) ? down_in.occ : right_in.occ;
      end else if (has_right) begin
         view.ext_go = right_in.occ;
      end else if (has_down) begin
         view.ext_dir = ytps_pkg::DIR_DOWN;
         view.ext_go = down_in.occ;
      end
   end

endmodule

FILE: src/young_tableau_priority_store.sv
// an accepted transaction walks one step per cycle through the cell chain, then waits in finish
// until the response register is free; a refused transaction goes straight from idle to finish
// the next transaction can be taken in the cycle in which the response is presented;
// a stalled response holds the walk in finish
// reset empties every cell and sets the region to the full grid
// depends on ytps_pkg and ytps_cell
module young_tableau_priority_store (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_kind,
   input  logic signed [31:0]  req_value,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_min_value,
   output logic [1:0]          rsp_status,
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [3:0]          csr_wdata
);

   localparam int NR = ytps_pkg::MAX_ROWS;
   localparam int NC = ytps_pkg::MAX_COLS;

   ytps_pkg::state_type state_ff, state_in;
   logic [ytps_pkg::RDIM_W-1:0] rows_ff, rows_in;
   logic [ytps_pkg::CDIM_W-1:0] cols_ff, cols_in;
   logic [ytps_pkg::ROW_W-1:0] row_ff, row_in;
   logic [ytps_pkg::COL_W-1:0] col_ff, col_in;
   logic [31:0] pend_value_ff, pend_value_in;
   ytps_pkg::status_type pend_status_ff, pend_status_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_value_ff, rsp_value_in;
   ytps_pkg::status_type rsp_status_ff, rsp_status_in;

   ytps_pkg::cell_cmd_type cmd;
   ytps_pkg::cell_data_type grid [NR][NC];
   ytps_pkg::cell_view_type views [NR][NC];
   ytps_pkg::cell_view_type pick;
   logic [NR*NC-1:0] sel_vec;
   logic req_take, rsp_free;

   genvar gr, gc;
   generate
      for (gr = 0; gr < NR; gr++) begin : g_row
         for (gc = 0; gc < NC; gc++) begin : g_col
            ytps_pkg::cell_data_type up_w, left_w, right_w, down_w;
            assign up_w = (gr > 0) ? grid[(gr > 0) ? gr - 1 : 0][gc] : ytps_pkg::CELL_EMPTY;
            assign left_w = (gc > 0) ? grid[gr][(gc > 0) ? gc - 1 : 0] : ytps_pkg::CELL_EMPTY;
            assign right_w = (gc < NC - 1) ? grid[gr][(gc < NC - 1) ? gc + 1 : gc]
                                           : ytps_pkg::CELL_EMPTY;
            assign down_w = (gr < NR - 1) ? grid[(gr < NR - 1) ? gr + 1 : gr][gc]
                                          : ytps_pkg::CELL_EMPTY;
            assign grid[gr][gc] = views[gr][gc].data;
            assign sel_vec[gr*NC + gc] = views[gr][gc].sel;
            ytps_cell u_cell (
               .clock    (clock),
               .reset    (reset),
               .my_row   (ytps_pkg::ROW_W'(gr)),
               .my_col   (ytps_pkg::COL_W'(gc)),
               .cmd      (cmd),
               .up_in    (up_w),
               .left_in  (left_w),
               .right_in (right_w),
               .down_in  (down_w),
               .view     (views[gr][gc])
            );
         end
      end
   endgenerate

   // one-hot select of the walk position's cell
   always_comb begin
      pick = '0;
      for (int r = 0; r < NR; r++) begin
         for (int c = 0; c < NC; c++) begin
            if (views[r][c].sel) begin
               pick = pick | views[r][c];
            end
         end
      end
   end

   assign req_stall = (state_ff != ytps_pkg::S_IDLE);
   assign req_take = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      row_in = row_ff;
      col_in = col_ff;
      pend_value_in = pend_value_ff;
      pend_status_in = pend_status_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      rsp_status_in = rsp_status_ff;

      cmd.op = ytps_pkg::OP_NONE;
      cmd.row = row_ff;
      cmd.col = col_ff;
      cmd.dir = ytps_pkg::DIR_UP;
      cmd.rows = rows_ff;
      cmd.cols = cols_ff;
      cmd.load_val = req_value;

      case (state_ff)
         ytps_pkg::S_IDLE: begin
            if (req_kind == ytps_pkg::KIND_EXTRACT) begin
               cmd.row = '0;
               cmd.col = '0;
            end else begin
               cmd.row = ytps_pkg::ROW_W'(rows_ff - 1'b1);
               cmd.col = ytps_pkg::COL_W'(cols_ff - 1'b1);
            end
            if (req_take) begin
               row_in = cmd.row;
               col_in = cmd.col;
               pend_value_in = '0;
               pend_status_in = ytps_pkg::ST_DONE;
               state_in = ytps_pkg::S_FINISH;
               if (req_kind == ytps_pkg::KIND_EXTRACT) begin
                  if (!pick.data.occ) begin
                     pend_status_in = ytps_pkg::ST_EXTRACT_EMPTY;
                  end else begin
                     cmd.op = ytps_pkg::OP_CLEAR;
                     pend_value_in = pick.data.val;
                     state_in = ytps_pkg::S_EXT_WALK;
                  end
               end else begin
                  if (pick.data.occ) begin
                     pend_status_in = ytps_pkg::ST_INSERT_FULL;
                  end else begin
                     cmd.op = ytps_pkg::OP_LOAD;
                     state_in = ytps_pkg::S_INS_WALK;
                  end
               end
            end
         end
         ytps_pkg::S_INS_WALK: begin
            cmd.dir = pick.ins_dir;
            if (pick.ins_go) begin
               cmd.op = ytps_pkg::OP_SWAP;
               if (pick.ins_dir == ytps_pkg::DIR_UP) begin
                  row_in = row_ff - 1'b1;
               end else begin
                  col_in = col_ff - 1'b1;
               end
            end else begin
               state_in = ytps_pkg::S_FINISH;
            end
         end
         ytps_pkg::S_EXT_WALK: begin
            cmd.dir = pick.ext_dir;
            if (pick.ext_go) begin
               cmd.op = ytps_pkg::OP_SWAP;
               if (pick.ext_dir == ytps_pkg::DIR_DOWN) begin
                  row_in = row_ff + 1'b1;
               end else begin
                  col_in = col_ff + 1'b1;
               end
            end else begin
               state_in = ytps_pkg::S_FINISH;
            end
         end
         ytps_pkg::S_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = pend_value_ff;
               rsp_status_in = pend_status_ff;
               state_in = ytps_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ytps_pkg::S_IDLE;
         end
      endcase
   end

   // region registers, saturated into range
   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (csr_we) begin
         case (csr_index)
            ytps_pkg::CSR_ROWS: begin
               if (csr_wdata == '0) begin
                  rows_in = ytps_pkg::RDIM_W'(1);
               end else if (32'(csr_wdata) > 32'(NR)) begin
                  rows_in = ytps_pkg::RDIM_W'(NR);
               end else begin
                  rows_in = ytps_pkg::RDIM_W'(csr_wdata);
               end
            end
            default: begin
               if (csr_wdata == '0) begin
                  cols_in = ytps_pkg::CDIM_W'(1);
               end else if (32'(csr_wdata) > 32'(NC)) begin
                  cols_in = ytps_pkg::CDIM_W'(NC);
               end else begin
                  cols_in = ytps_pkg::CDIM_W'(csr_wdata);
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ytps_pkg::S_IDLE;
         rows_ff <= ytps_pkg::RDIM_W'(NR);
         cols_ff <= ytps_pkg::CDIM_W'(NC);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rows_ff <= rows_in;
         cols_ff <= cols_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      row_ff <= row_in;
      col_ff <= col_in;
      pend_value_ff <= pend_value_in;
      pend_status_ff <= pend_status_in;
      rsp_value_ff <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_min_value = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

   a_take_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff != ytps_pkg::S_IDLE)
      else $error("accepted transaction did not start");

   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != ytps_pkg::ST_DONE |-> rsp_value_ff == '0)
      else $error("refused transaction carries a value");

   a_one_position: assert property (@(posedge clock) disable iff (reset)
      state_ff != ytps_pkg::S_FINISH |-> $onehot(sel_vec))
      else $error("walk position does not select exactly one cell");

   a_walk_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == ytps_pkg::S_FINISH && rsp_free |=> rsp_valid_ff)
      else $error("finished transaction not delivered");

endmodule

FILE: tb/sv/young_tableau_priority_store_tb.sv
// self-checking testbench for the young tableau priority store
// drives insert and extract transactions, predicts each response and compares
// depends on ytps_pkg and young_tableau_priority_store
module young_tableau_priority_store_tb;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_kind = 1'b0;
   logic signed [31:0] req_value = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_min_value;
   logic [1:0] rsp_status;
   logic csr_we = 1'b0;
   logic csr_index = 1'b0;
   logic [3:0] csr_wdata = '0;

   young_tableau_priority_store dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   typedef struct {
      logic signed [31:0] min_value;
      logic [1:0]         status;
   } outcome_type;

   // tableau mirror
   logic signed [31:0] grid_val [ytps_pkg::MAX_ROWS][ytps_pkg::MAX_COLS];
   logic               grid_occ [ytps_pkg::MAX_ROWS][ytps_pkg::MAX_COLS];
   int                 rows_n = ytps_pkg::MAX_ROWS;
   int                 cols_n = ytps_pkg::MAX_COLS;
   outcome_type        pending_q[$];
   int                 mismatches = 0;
   int                 checked = 0;
   int                 sent = 0;
   int                 hold_cycles = 0;
   int                 refusals = 0;

   function automatic bit is_less(int ai, int aj, int bi, int bj);
      if (!grid_occ[ai][aj]) return 1'b0;
      if (!grid_occ[bi][bj]) return 1'b1;
      return grid_val[ai][aj] < grid_val[bi][bj];
   endfunction

   function automatic void swap_cells(int ai, int aj, int bi, int bj);
      logic signed [31:0] v;
      logic o;
      v = grid_val[ai][aj]; o = grid_occ[ai][aj];
      grid_val[ai][aj] = grid_val[bi][bj]; grid_occ[ai][aj] = grid_occ[bi][bj];
      grid_val[bi][bj] = v; grid_occ[bi][bj] = o;
   endfunction

   function automatic int clamp_dim(logic [3:0] v, int lim);
      if (v == 0) return 1;
      if (v > lim) return lim;
      return v;
   endfunction

   function automatic outcome_type tableau_step(ytps_pkg::kind_type kind,
                                                logic signed [31:0] value);
      outcome_type res;
      int i, j, ni, nj;
      res.min_value = '0;
      res.status = ytps_pkg::ST_DONE;
      if (kind == ytps_pkg::KIND_INSERT) begin
         i = rows_n - 1; j = cols_n - 1;
         if (grid_occ[i][j]) begin
            res.status = ytps_pkg::ST_INSERT_FULL;
            return res;
         end
         grid_val[i][j] = value; grid_occ[i][j] = 1'b1;
         forever begin
            if (i > 0 && j > 0) begin
               if (!is_less(i-1, j, i, j-1)) begin ni = i-1; nj = j; end
               else begin ni = i; nj = j-1; end
            end else if (i > 0) begin ni = i-1; nj = j; end
            else if (j > 0) begin ni = i; nj = j-1; end
            else break;
            if (!is_less(i, j, ni, nj)) break;
            swap_cells(i, j, ni, nj);
            i = ni; j = nj;
         end
         return res;
      end
      if (!grid_occ[0][0]) begin
         res.status = ytps_pkg::ST_EXTRACT_EMPTY;
         return res;
      end
      res.min_value = grid_val[0][0];
      grid_val[0][0] = '0; grid_occ[0][0] = 1'b0;
      i = 0; j = 0;
      forever begin
         if (i+1 < rows_n && j+1 < cols_n) begin
            if (!is_less(i+1, j, i, j+1)) begin ni = i; nj = j+1; end
            else begin ni = i+1; nj = j; end
         end else if (j+1 < cols_n) begin ni = i; nj = j+1; end
         else if (i+1 < rows_n) begin ni = i+1; nj = j; end
         else break;
         if (!grid_occ[ni][nj]) break;
         swap_cells(i, j, ni, nj);
         i = ni; j = nj;
      end
      return res;
   endfunction

   // valid stays high after acceptance when the next transaction follows with no gap
   task automatic send_item(ytps_pkg::kind_type kind, logic signed [31:0] value);
      int gap;
      outcome_type res;
      gap = $urandom_range(0, 9);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_value <= value;
      do @(posedge clock); while (req_stall);
      res = tableau_step(kind, value);
      pending_q = {pending_q, res};
      if (kind == ytps_pkg::KIND_INSERT && res.status == ytps_pkg::ST_INSERT_FULL) refusals++;
      if (kind == ytps_pkg::KIND_EXTRACT && res.status == ytps_pkg::ST_EXTRACT_EMPTY)
         refusals++;
      sent++;
   endtask

   task automatic write_csr(ytps_pkg::csr_index_type idx, logic [3:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == ytps_pkg::CSR_ROWS) rows_n = clamp_dim(data, ytps_pkg::MAX_ROWS);
      else cols_n = clamp_dim(data, ytps_pkg::MAX_COLS);
      @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (2 * (ytps_pkg::MAX_ROWS + ytps_pkg::MAX_COLS) + 4) @(posedge clock);
   endtask

   // drain all cells so a region change starts from an empty tableau
   task automatic empty_store();
      int count;
      count = 0;
      for (int r = 0; r < ytps_pkg::MAX_ROWS; r++)
         for (int c = 0; c < ytps_pkg::MAX_COLS; c++)
            if (grid_occ[r][c]) count++;
      repeat (count + 1) send_item(ytps_pkg::KIND_EXTRACT, $urandom);
      drain();
   endtask

   // response checker with random stall
   initial begin
      outcome_type exp_res;
      int wait_n;
      wait_n = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) begin
            if (pending_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected transaction %0d/%0d",
                  rsp_min_value, rsp_status);
            end else begin
               exp_res = pending_q.pop_front();
               checked++;
               if (exp_res.min_value !== rsp_min_value || exp_res.status !== rsp_status) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("transaction %0d: expected %0d/%0d got %0d/%0d", checked,
                        exp_res.min_value, exp_res.status, rsp_min_value, rsp_status);
               end
            end
            wait_n = $urandom_range(0, 9);
            if (sent > 1200 && sent < 1400) wait_n = 0;
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_stall <= 1'b1;
         end else if (wait_n > 0) begin
            wait_n--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   typedef struct {
      ytps_pkg::kind_type kind;
      logic signed [31:0] value;
      logic [1:0]         want_status;
      logic signed [31:0] want_min;
      bit                 literal;
   } row_type;

   row_type plan[] = '{
      '{ytps_pkg::KIND_EXTRACT, 32'sd0, ytps_pkg::ST_EXTRACT_EMPTY, 32'sd0, 1'b1},
      '{ytps_pkg::KIND_INSERT, 32'h7fffffff, ytps_pkg::ST_DONE, 32'sd0, 1'b1},
      '{ytps_pkg::KIND_INSERT, 32'h80000000, ytps_pkg::ST_DONE, 32'sd0, 1'b1},
      '{ytps_pkg::KIND_INSERT, -32'sd1, ytps_pkg::ST_DONE, 32'sd0, 1'b1},
      '{ytps_pkg::KIND_INSERT, 32'sd0, ytps_pkg::ST_DONE, 32'sd0, 1'b1},
      '{ytps_pkg::KIND_INSERT, 32'sd5, ytps_pkg::ST_DONE, 32'sd0, 1'b1},
      '{ytps_pkg::KIND_INSERT, 32'sd5, ytps_pkg::ST_DONE, 32'sd0, 1'b1},
      '{ytps_pkg::KIND_EXTRACT, 32'hffffffff, ytps_pkg::ST_DONE, 32'h80000000, 1'b1},
      '{ytps_pkg::KIND_EXTRACT, 32'sd0, ytps_pkg::ST_DONE, 32'sd0, 1'b0},
      '{ytps_pkg::KIND_INSERT, 32'h55555555, ytps_pkg::ST_DONE, 32'sd0, 1'b0},
      '{ytps_pkg::KIND_INSERT, 32'haaaaaaaa, ytps_pkg::ST_DONE, 32'sd0, 1'b0},
      '{ytps_pkg::KIND_EXTRACT, 32'sd0, ytps_pkg::ST_DONE, 32'sd0, 1'b0},
      '{ytps_pkg::KIND_EXTRACT, 32'sd0, ytps_pkg::ST_DONE, 32'sd0, 1'b0},
      '{ytps_pkg::KIND_EXTRACT, 32'sd0, ytps_pkg::ST_DONE, 32'sd0, 1'b0},
      '{ytps_pkg::KIND_EXTRACT, 32'sd0, ytps_pkg::ST_DONE, 32'sd0, 1'b0},
      '{ytps_pkg::KIND_EXTRACT, 32'sd0, ytps_pkg::ST_DONE, 32'sd0, 1'b0},
      '{ytps_pkg::KIND_EXTRACT, 32'sd0, ytps_pkg::ST_DONE, 32'sd0, 1'b0},
      '{ytps_pkg::KIND_EXTRACT, 32'sd0, ytps_pkg::ST_EXTRACT_EMPTY, 32'sd0, 1'b1}
   };

   initial begin
      logic [3:0] rdim [6] = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd2};
      logic [3:0] cdim [6] = '{4'd1, 4'd8, 4'd4, 4'd0, 4'd9, 4'd7};
      int phase_items;
      logic signed [31:0] v;
      outcome_type guess;
      for (int r = 0; r < ytps_pkg::MAX_ROWS; r++)
         for (int c = 0; c < ytps_pkg::MAX_COLS; c++) begin
            grid_val[r][c] = '0;
            grid_occ[r][c] = 1'b0;
         end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[k]) begin
         send_item(plan[k].kind, plan[k].value);
         if (plan[k].literal) begin
            guess = pending_q[$];
            if (guess.status !== plan[k].want_status || guess.min_value !== plan[k].want_min)
            begin
               mismatches++;
               $display("table row %0d disagrees with prediction", k);
            end
         end
      end
      drain();

      // fill the full grid past capacity, then back off the receiver
      for (int k = 0; k < 66; k++) send_item(ytps_pkg::KIND_INSERT, $urandom);
      hold_cycles = 300;
      for (int k = 0; k < 30; k++) send_item(ytps_pkg::KIND_EXTRACT, 0);
      for (int k = 0; k < 20; k++) send_item(ytps_pkg::KIND_INSERT, $urandom_range(0, 7) - 4);
      drain();
      empty_store();

      for (int p = 0; p < 6; p++) begin
         write_csr(ytps_pkg::CSR_ROWS, rdim[p]);
         write_csr(ytps_pkg::CSR_COLS, cdim[p]);
         phase_items = 250;
         for (int k = 0; k < phase_items; k++) begin
            case ($urandom_range(0, 3))
               0: v = $urandom;
               1: v = $urandom_range(0, 6) - 3;
               2: v = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
               default: v = $urandom_range(0, 1000);
            endcase
            // bias toward inserts in the first half of each 80-item window so the tableau fills
            if ($urandom_range(0, 99) < ((k % 80) < 40 ? 70 : 30))
               send_item(ytps_pkg::KIND_INSERT, v);
            else
               send_item(ytps_pkg::KIND_EXTRACT, v);
         end
         drain();
         empty_store();
      end

      // region change with the tableau partly full
      write_csr(ytps_pkg::CSR_ROWS, 4'd8);
      write_csr(ytps_pkg::CSR_COLS, 4'd8);
      for (int k = 0; k < 20; k++) send_item(ytps_pkg::KIND_INSERT, $urandom);
      drain();
      write_csr(ytps_pkg::CSR_ROWS, 4'd2);
      write_csr(ytps_pkg::CSR_COLS, 4'd3);
      for (int k = 0; k < 30; k++)
         send_item(ytps_pkg::kind_type'($urandom_range(0, 1)), $urandom);
      drain();

      $display("%0d transactions sent, %0d responses checked, %0d refusals, six region sizes",
         sent, checked, refusals);
      if (mismatches == 0 && pending_q.size() == 0) begin
         $display("young_tableau_priority_store: match");
      end else begin
         $display("young_tableau_priority_store: mismatch");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("young_tableau_priority_store: mismatch");
      $finish;
   end

endmodule
